// ===== hdl/tamag_pkg.sv =====
`default_nettype none

package tamag_pkg;

  localparam int unsigned DEF_SAMPLE_WIDTH  = 16;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // Smoothing weight: unsigned Q0.16 fraction.
  localparam int unsigned ALPHA_W = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6237;

  // Magnitude width, unsigned with 8 fraction bits.
  localparam int unsigned OUT_W = 24;

  // Per-request controls that the top level hands to every axis lane.
  typedef struct packed {
    logic start;   // request accepted this cycle
    logic load;    // first good sample: load the raw value
    logic update;  // good sample after priming: move the average
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/tamag_lane.sv =====
`default_nettype none

module tamag_lane #(
  parameter int unsigned SAMPLE_WIDTH  = tamag_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned FRACTION_BITS = tamag_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tamag_pkg::lane_ctl_t                ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  input  logic [tamag_pkg::ALPHA_W-1:0]       alpha_i,
  output logic                                valid_o,
  output logic [2*(SAMPLE_WIDTH+8)-1:0]       sq_o
);
  import tamag_pkg::*;

  localparam int unsigned AVW = SAMPLE_WIDTH + FRACTION_BITS;
  localparam int unsigned AW  = SAMPLE_WIDTH + 8;
  localparam int unsigned SH  = FRACTION_BITS - 8;
  localparam int unsigned PW  = AVW + ALPHA_W;
  localparam logic [PW:0] CEIL_ADD = (PW+1)'((1 << ALPHA_W) - 1);
  localparam logic signed [AVW+1:0] RND_HALF = (AVW+2)'(1) << SH;

  logic signed [AVW-1:0] avg_q;
  logic [4:0]            vld_q;
  logic                  upd_q;
  logic                  neg_q;
  logic [AVW-1:0]        mag_q;
  logic [PW-1:0]         prod_q;
  logic [AW-1:0]         abs_q;
  logic [2*AW-1:0]       sq_q;

  logic signed [AVW-1:0] target;
  logic signed [AVW:0]   diff;
  logic signed [AVW:0]   diff_abs;
  logic [PW:0]           step_up;
  logic [AVW-1:0]        step;
  logic signed [AVW-1:0] avg_d;
  logic signed [AVW+1:0] rnd;
  logic signed [AVW+1:0] rnd_sh;
  logic signed [AW:0]    qv;
  logic signed [AW:0]    qv_abs;

  always_comb begin
    target   = {sample_i, {FRACTION_BITS{1'b0}}};
    diff     = {target[AVW-1], target} - {avg_q[AVW-1], avg_q};
    diff_abs = diff[AVW] ? -diff : diff;
    // A negative move rounds its magnitude up so the average floors overall.
    step_up  = {1'b0, prod_q} + (neg_q ? CEIL_ADD : '0);
    step     = AVW'(step_up >> ALPHA_W);
    avg_d    = neg_q ? avg_q - $signed(step) : avg_q + $signed(step);
    // Round to 8 fraction bits, ties up, via one extra guard bit.
    rnd      = $signed({avg_q[AVW-1], avg_q, 1'b0}) + RND_HALF;
    rnd_sh   = rnd >>> (SH + 1);
    qv       = rnd_sh[AW:0];
    qv_abs   = qv[AW] ? -qv : qv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      upd_q <= 1'b0;
      avg_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], ctl_i.start};
      if (ctl_i.start) begin
        upd_q <= ctl_i.update;
      end
      if (ctl_i.start && ctl_i.load) begin
        avg_q <= target;
      end else if (vld_q[1] && upd_q) begin
        avg_q <= avg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      neg_q <= diff[AVW];
      mag_q <= diff_abs[AVW-1:0];
    end
    if (vld_q[0]) begin
      prod_q <= PW'(mag_q * alpha_i);
    end
    if (vld_q[2]) begin
      abs_q <= qv_abs[AW-1:0];
    end
    if (vld_q[3]) begin
      sq_q <= abs_q * abs_q;
    end
  end

  assign valid_o = vld_q[4];
  assign sq_o    = sq_q;

endmodule

`default_nettype wire

// ===== hdl/tamag_merge.sv =====
`default_nettype none

module tamag_merge #(
  parameter int unsigned SAMPLE_WIDTH = tamag_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [2*(SAMPLE_WIDTH+8)-1:0]     sq_i [3],
  output logic                              done_o,
  output logic [tamag_pkg::OUT_W-1:0]       mag_o
);
  import tamag_pkg::*;

  localparam int unsigned RW   = SAMPLE_WIDTH + 9;
  localparam int unsigned SUMW = 2 * RW;
  localparam int unsigned RMW  = RW + 2;
  localparam int unsigned CW   = $clog2(RW + 1);
  localparam int unsigned XW   = (RW > OUT_W) ? RW : OUT_W;
  localparam logic [XW-1:0] OUT_MAX = XW'({OUT_W{1'b1}});

  logic [SUMW-1:0] rad_q;
  logic [RMW-1:0]  rem_q;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [SUMW-1:0] sum;
  logic [RMW-1:0]  rem_sh;
  logic [RMW-1:0]  trial;
  logic            fits;
  logic [XW-1:0]   root_x;

  always_comb begin
    sum    = SUMW'(sq_i[0]) + SUMW'(sq_i[1]) + SUMW'(sq_i[2]);
    // One root bit per cycle: bring down two radicand bits, try 4*root+1.
    rem_sh = {rem_q[RMW-3:0], rad_q[SUMW-1 -: 2]};
    trial  = {root_q, 2'b01};
    fits   = rem_sh >= trial;
    root_x = XW'(root_q);
    mag_o  = (root_x > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(root_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= sum;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RW-2:0], fits};
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hdl/three_axis_ema_magnitude_core.sv =====
// Flow: a request runs through the axis lane pipelines, then the shared bit-serial square root,
// one root bit per cycle; the result then enters the output register for m_axis.
// Only one request is taken at a time: the next waits until the result has entered the output
// register, so a finished result may wait there while the next request runs.
// Reset: rst_ni is asynchronous, active low; it clears the averages and the primed flag,
// empties the output register and sets the smoothing weight to 6237.
`default_nettype none

module three_axis_ema_magnitude_core #(
  parameter int unsigned SAMPLE_WIDTH  = tamag_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned FRACTION_BITS = tamag_pkg::DEF_FRACTION_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration: smoothing weight, unsigned Q0.16.
  input  logic                                   cfg_we_i,
  input  logic [tamag_pkg::ALPHA_W-1:0]          cfg_wdata_i,
  // Request stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata from bit 0: axis_x, axis_y, axis_z, zero fill.
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // tuser: read_ok.
  input  logic                                   s_axis_tuser,
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata from bit 0: magnitude.
  output logic [tamag_pkg::OUT_W-1:0]            m_axis_tdata
);
  import tamag_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LANES = 4'b0010,
    ST_ROOT  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  localparam int unsigned SQW = 2 * (SAMPLE_WIDTH + 8);

  state_e               state_q, state_d;
  logic [ALPHA_W-1:0]   alpha_q;
  logic                 primed_q;
  logic                 m_valid_q, m_valid_d;
  logic [OUT_W-1:0]     m_data_q;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  lane_ctl_t            lane_ctl;
  logic signed [SAMPLE_WIDTH-1:0] sample [3];
  logic [2:0]           lane_vld;
  logic [SQW-1:0]       lane_sq [3];
  logic                 root_done;
  logic [OUT_W-1:0]     root_mag;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    sample[0] = s_axis_tdata[SAMPLE_WIDTH-1:0];
    sample[1] = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    sample[2] = s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
    lane_ctl.start  = accept;
    lane_ctl.load   = s_axis_tuser && !primed_q;
    lane_ctl.update = s_axis_tuser && primed_q;
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    tamag_lane #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .sample_i (sample[g]),
      .alpha_i  (alpha_q),
      .valid_o  (lane_vld[g]),
      .sq_o     (lane_sq[g])
    );
  end

  tamag_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_vld[0]),
    .sq_i    (lane_sq),
    .done_o  (root_done),
    .mag_o   (root_mag)
  );

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LANES;
        end
      end
      ST_LANES: begin
        if (lane_vld[0]) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      alpha_q   <= ALPHA_RESET;
      primed_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      if (accept && s_axis_tuser) begin
        primed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= root_mag;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Only one request is ever in flight.
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_vld[0] == lane_vld[1]) && (lane_vld[0] == lane_vld[2]))
    else $error("axis lanes out of step");

  a_primed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("primed flag cleared without reset");

  a_root_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == ST_ROOT))
    else $error("square root finished outside the root state");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(root_done) || $past(state_q == ST_HOLD)))
    else $error("result shown without a finished square root");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tamag_pkg::*;

  localparam int SW = DEF_SAMPLE_WIDTH;
  localparam int FB = DEF_FRACTION_BITS;
  localparam int DATA_W = ((3 * SW + 7) / 8) * 8;
  localparam int LATENCY = SW + 15;
  localparam longint CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
    logic                 ok;
    int unsigned          gap;
    bit                   hold_off;
  } field_sample_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [ALPHA_W-1:0] cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;

  three_axis_ema_magnitude_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Mirrored filter state and smoothing weight.
  longint avg_x, avg_y, avg_z;
  bit     primed;
  int     alpha_weight = int'(ALPHA_RESET);

  field_sample_t    sample_queue[$];
  logic [OUT_W-1:0] mag_expected[$];
  field_sample_t    in_flight;

  int     n_predicted = 0;
  int     n_checked = 0;
  int     errors = 0;
  int     n_failed_reads = 0;
  int     n_weights = 1;
  longint cycles = 0;

  bit          src_calm = 1'b0;
  int unsigned gap_waited = 0;
  bit          src_took, src_drained, src_present;

  bit               sink_calm = 1'b0;
  int               sink_calm_left = 0;
  int unsigned      sink_wait = 0;
  logic [OUT_W-1:0] mag_want;

  function automatic longint ema_move(longint avg, longint sample);
    longint diff;
    diff = (sample <<< FB) - avg;
    // Floor of the scaled step for both signs of the difference.
    return avg + ((diff * longint'(alpha_weight)) >>> ALPHA_W);
  endfunction

  function automatic longint unsigned round_q8_abs(longint v);
    longint r;
    r = (v + (longint'(1) <<< (FB - 9))) >>> (FB - 8);
    return (r < 0) ? longint'(-r) : r;
  endfunction

  function automatic logic [OUT_W-1:0] floor_root(longint unsigned n);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    if (root > (64'd1 << OUT_W) - 1) root = (64'd1 << OUT_W) - 1;
    return root[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] advance_filter(field_sample_t s);
    longint unsigned ax, ay, az;
    if (s.ok) begin
      if (!primed) begin
        avg_x = longint'(s.x) <<< FB;
        avg_y = longint'(s.y) <<< FB;
        avg_z = longint'(s.z) <<< FB;
        primed = 1'b1;
      end else begin
        avg_x = ema_move(avg_x, s.x);
        avg_y = ema_move(avg_y, s.y);
        avg_z = ema_move(avg_z, s.z);
      end
    end
    ax = round_q8_abs(avg_x);
    ay = round_q8_abs(avg_y);
    az = round_q8_abs(avg_z);
    return floor_root(ax * ax + ay * ay + az * az);
  endfunction

  function automatic logic signed [SW-1:0] clip_sample(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[SW-1:0];
  endfunction

  // Request side: one request at a time, with a drawn gap before each.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      n_predicted   <= 0;
      gap_waited = 0;
    end else begin
      src_took = s_axis_tvalid && s_axis_tready;
      src_drained = !src_took &&
          (n_predicted == n_checked + int'(m_axis_tvalid && m_axis_tready));
      if (src_took) begin
        mag_expected.push_back(advance_filter(in_flight));
        n_predicted <= n_predicted + 1;
      end
      if (!s_axis_tvalid || src_took) begin
        src_present = 1'b0;
        if (sample_queue.size() != 0) begin
          if (gap_waited < sample_queue[0].gap) begin
            gap_waited++;
          end else if (!sample_queue[0].hold_off || src_drained) begin
            in_flight = sample_queue.pop_front();
            gap_waited = 0;
            src_present = 1'b1;
            s_axis_tdata <= {in_flight.z, in_flight.y, in_flight.x};
            s_axis_tuser <= in_flight.ok;
          end
        end
        s_axis_tvalid <= src_present;
      end
    end
  end

  // Result side: checks each magnitude; outside calm stretches it drops tready after each
  // result and raises it again after a drawn wait once the next result is presented.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      n_checked     <= 0;
      sink_wait = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (mag_expected.size() == 0) begin
        $display("%0t: unexpected magnitude, expected none, got %0d", $time, m_axis_tdata);
        errors++;
      end else begin
        mag_want = mag_expected.pop_front();
        if (m_axis_tdata !== mag_want) begin
          $display("%0t: magnitude mismatch, expected %0d, got %0d",
                   $time, mag_want, m_axis_tdata);
          errors++;
        end
      end
      n_checked <= n_checked + 1;
      if (sink_calm_left == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
        sink_calm_left = 50;
      end
      sink_calm_left--;
      sink_wait = sink_calm ? 0 : $urandom_range(0, 9);
      m_axis_tready <= sink_calm;
    end else if (!m_axis_tready && m_axis_tvalid) begin
      if (sink_wait == 0) m_axis_tready <= 1'b1;
      else sink_wait--;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d magnitudes outstanding", $time, mag_expected.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_sample(int x, int y, int z, bit ok, bit hold_off = 1'b0);
    field_sample_t s;
    s.x = clip_sample(x);
    s.y = clip_sample(y);
    s.z = clip_sample(z);
    s.ok = ok;
    s.gap = src_calm ? 0 : $urandom_range(0, 9);
    s.hold_off = hold_off;
    if (!ok) n_failed_reads++;
    sample_queue.push_back(s);
  endtask

  // Mostly slowly wandering field values with sensor noise, some full-range
  // samples, and occasional failed reads.
  task automatic push_random(int count);
    int base_x, base_y, base_z, spread, wild;
    base_x = 0;
    base_y = 0;
    base_z = 0;
    spread = 1;
    wild = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        src_calm = ($urandom_range(0, 3) == 0);
        spread = 1 << $urandom_range(0, 13);
        wild = ($urandom_range(0, 3) == 0);
        base_x = $signed($urandom_range(0, 65535)) - 32768;
        base_y = $signed($urandom_range(0, 65535)) - 32768;
        base_z = $signed($urandom_range(0, 65535)) - 32768;
      end
      if (wild || $urandom_range(0, 9) == 0) begin
        push_sample($signed($urandom_range(0, 65535)) - 32768,
                    $signed($urandom_range(0, 65535)) - 32768,
                    $signed($urandom_range(0, 65535)) - 32768,
                    $urandom_range(0, 7) != 0, $urandom_range(0, 99) == 0);
      end else begin
        base_x += $signed($urandom_range(0, 64)) - 32;
        base_y += $signed($urandom_range(0, 64)) - 32;
        base_z += $signed($urandom_range(0, 64)) - 32;
        push_sample(base_x + $signed($urandom_range(0, 2 * spread)) - spread,
                    base_y + $signed($urandom_range(0, 2 * spread)) - spread,
                    base_z + $signed($urandom_range(0, 2 * spread)) - spread,
                    $urandom_range(0, 7) != 0, $urandom_range(0, 99) == 0);
      end
    end
    src_calm = 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || s_axis_tvalid || mag_expected.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_alpha(int value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[ALPHA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    alpha_weight = value;
    n_weights++;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset weight: failed reads before the first good sample, then the load.
    push_sample(32767, -32768, 0, 1'b0);
    push_sample(-1, 1, 12345, 1'b0);
    push_sample(-32768, -32768, -32768, 1'b1);
    push_sample(32767, 32767, 32767, 1'b1);
    push_sample(-32768, 0, 32767, 1'b0);
    push_sample(0, 0, 0, 1'b1);
    push_sample(32767, -32768, 1, 1'b1);
    push_sample(-1, -1, -1, 1'b1, 1'b1);
    push_sample(1, 0, -1, 1'b1);

    write_alpha(65535);
    push_sample(32767, 32767, 32767, 1'b1);
    push_sample(-32768, -32768, -32768, 1'b1);
    push_sample(0, -1, 1, 1'b1);
    push_sample(12345, -23456, 32767, 1'b0);
    push_random(250);

    // A zero weight freezes the averages.
    write_alpha(0);
    push_sample(32767, -32768, 0, 1'b1);
    push_sample(1, 1, 1, 1'b1);
    push_sample(0, 0, 0, 1'b0);
    push_random(150);

    write_alpha(1);
    push_random(250);

    for (int p = 0; p < 4; p++) begin
      write_alpha($urandom_range(1, 65535));
      push_random(225);
    end

    write_alpha(32768);
    push_random(200);
    write_alpha(int'(ALPHA_RESET));
    push_random(150);

    wait_idle();
    repeat (LATENCY + 10) @(negedge clk_i);

    $display("Checked %0d magnitudes from %0d samples, %0d of them failed reads,",
             n_checked, n_predicted, n_failed_reads);
    $display("under %0d smoothing weights including 0, 1, 32768 and 65535.", n_weights);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
